// ----- sv/hjs_pkg.sv -----
// Shared types and constants for the HRRN job scheduler.
`timescale 1ns / 1ps

package hjs_pkg;

    localparam int MAX_JOBS_DEF = 8;

    localparam int ID_W   = 8;
    localparam int NEED_W = 16;
    localparam int WAIT_W = 16;
    localparam int SEQ_W  = 8;
    localparam int TIME_W = 32;
    localparam int SUM_W  = NEED_W + 1;
    localparam int PROD_W = SUM_W + NEED_W;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_FIELD_W = 1 + ID_W + 1 + ID_W + TIME_W + 1;
    localparam int OUT_TDATA_W = 56;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef enum logic [0:0] {
        OP_TICK   = 1'b0,
        OP_ARRIVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_MUL2,
        ST_CMP,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EXEC,
        CMD_SKIP,
        CMD_TAKE,
        CMD_MUL1,
        CMD_MUL2,
        CMD_CMP,
        CMD_PICK,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic done_hit;
        logic scan_valid;
        logic scan_last;
        logic found;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- sv/hrrn_job_scheduler_unit.sv -----
// Top level of the HRRN job scheduler.
`timescale 1ns / 1ps

// The scheduler takes one request at a time on the s_axis channel. A request with
// s_axis_tuser high is a job arrival carrying an id and a service need; with
// s_axis_tuser low it is one time tick. Every request yields exactly one result
// on the m_axis channel with the running job, a completion report and a
// table-full flag.
// An arrival or a tick that completes no job goes from acceptance through the
// execute step to the emit step, which registers the result.
// A tick that completes a job adds a sequential scan of the job table, one slot
// per cycle when empty or first found, while each further occupied slot goes
// through the shared ratio multiplier, a multiply step per cross product and then
// a compare step, and a pick step then starts the chosen job.
// Reset empties the table, stops the processor and clears the tick count.
// The result register holds its value while m_axis_tready is low; the next
// request is still accepted and worked on, and its result waits until the
// register is free.
module hrrn_job_scheduler_unit #(
    parameter int MAX_JOBS = hjs_pkg::MAX_JOBS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: job_id[7:0], service_need[23:8].
    input  logic [hjs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation[0].
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: running_valid[0], running_job[8:1], done_res[9],
    // done_job[17:10], finish_time[49:18], table_full[50], zero fill above.
    output logic [hjs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import hjs_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    hjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hjs_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_id     (s_axis_tdata[ID_W-1:0]),
        .in_need   (s_axis_tdata[ID_W+NEED_W-1:ID_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- sv/hjs_ctrl.sv -----
// Controller state machine of the HRRN job scheduler.
`timescale 1ns / 1ps

module hjs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hjs_pkg::dp_status_t status,
    output hjs_pkg::cmd_t      cmd
);
    import hjs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd        = CMD_EXEC;
                state_next = status.done_hit ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN:
            begin
                if (!status.scan_valid)
                begin
                    cmd        = CMD_SKIP;
                    state_next = status.scan_last ? ST_PICK : ST_SCAN;
                end
                else if (!status.found)
                begin
                    cmd        = CMD_TAKE;
                    state_next = status.scan_last ? ST_PICK : ST_SCAN;
                end
                else
                begin
                    cmd        = CMD_MUL1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd        = CMD_MUL2;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd        = CMD_CMP;
                state_next = status.scan_last ? ST_PICK : ST_SCAN;
            end
            ST_PICK:
            begin
                cmd        = CMD_PICK;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/hjs_dp.sv -----
// Datapath of the HRRN job scheduler: job table, timers, ratio compare and result register.
`timescale 1ns / 1ps

module hjs_dp #(
    parameter int MAX_JOBS = hjs_pkg::MAX_JOBS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hjs_pkg::cmd_t                   cmd,
    output hjs_pkg::dp_status_t             status,
    input  logic                            in_op,
    input  logic [hjs_pkg::ID_W-1:0]        in_id,
    input  logic [hjs_pkg::NEED_W-1:0]      in_need,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hjs_pkg::OUT_TDATA_W-1:0] out_data
);
    import hjs_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);

    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [NEED_W-1:0] need_reg;

    logic [MAX_JOBS-1:0] valid_reg;
    logic [ID_W-1:0]     job_reg    [MAX_JOBS];
    logic [NEED_W-1:0]   need_arr_reg [MAX_JOBS];
    logic [WAIT_W-1:0]   waited_reg [MAX_JOBS];
    logic [SEQ_W-1:0]    seq_reg    [MAX_JOBS];

    logic [IDX_W-1:0]  run_slot_reg;
    logic              run_active_reg;
    logic [NEED_W-1:0] run_served_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SEQ_W-1:0]  next_seq_reg;

    logic              res_done_reg;
    logic [ID_W-1:0]   res_done_job_reg;
    logic [TIME_W-1:0] res_fin_reg;
    logic              res_full_reg;

    logic [IDX_W-1:0]  scan_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SUM_W-1:0]  best_sum_reg;
    logic [NEED_W-1:0] best_need_reg;
    logic [SEQ_W-1:0]  best_age_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [NEED_W-1:0] served_inc;
    logic              tick_done;
    logic              done_now;
    logic [NEED_W-1:0] cur_need;
    logic [SUM_W-1:0]  cur_sum;
    logic [SEQ_W-1:0]  cur_age;
    logic [SUM_W-1:0]  mul_a;
    logic [NEED_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;
    logic              beat;
    logic [ID_W-1:0]   run_job;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign served_inc = run_served_reg + NEED_W'(1);
    assign tick_done  = run_active_reg && (served_inc >= need_arr_reg[run_slot_reg]);
    assign done_now   = (op_reg == OP_TICK) && tick_done;

    assign cur_need = need_arr_reg[scan_idx_reg];
    assign cur_sum  = {1'b0, cur_need} + {1'b0, waited_reg[scan_idx_reg]};
    assign cur_age  = next_seq_reg - seq_reg[scan_idx_reg];

    // The one multiplier serves both cross products of a comparison.
    assign mul_a = (cmd == CMD_MUL1) ? cur_sum : best_sum_reg;
    assign mul_b = (cmd == CMD_MUL1) ? best_need_reg : cur_need;
    assign prod  = mul_a * mul_b;

    assign beat = (prod_a_reg > prod_b_reg) ||
                  ((prod_a_reg == prod_b_reg) && (cur_age > best_age_reg));

    assign run_job = run_active_reg ? job_reg[run_slot_reg] : '0;

    assign status.done_hit   = done_now;
    assign status.scan_valid = valid_reg[scan_idx_reg];
    assign status.scan_last  = (scan_idx_reg == LAST_IDX);
    assign status.found      = found_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            run_slot_reg   <= '0;
            run_active_reg <= 1'b0;
            run_served_reg <= '0;
            now_reg        <= '0;
            next_seq_reg   <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_EXEC:
                begin
                    if (op_reg == OP_ARRIVE)
                    begin
                        if (free_found)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            next_seq_reg        <= next_seq_reg + SEQ_W'(1);
                            if (!run_active_reg)
                            begin
                                run_active_reg <= 1'b1;
                                run_slot_reg   <= free_idx;
                                run_served_reg <= '0;
                            end
                        end
                    end
                    else
                    begin
                        now_reg <= now_reg + TIME_W'(1);
                        if (run_active_reg)
                        begin
                            run_served_reg <= served_inc;
                            if (tick_done)
                            begin
                                valid_reg[run_slot_reg] <= 1'b0;
                                scan_idx_reg            <= '0;
                                found_reg               <= 1'b0;
                            end
                        end
                    end
                end
                CMD_SKIP:
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                CMD_TAKE:
                begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= scan_idx_reg;
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                CMD_CMP:
                begin
                    if (beat)
                    begin
                        best_idx_reg <= scan_idx_reg;
                    end
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                CMD_PICK:
                begin
                    run_active_reg <= found_reg;
                    run_slot_reg   <= found_reg ? best_idx_reg : '0;
                    run_served_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg   <= op_t'(in_op);
                id_reg   <= in_id;
                need_reg <= in_need;
            end
            CMD_EXEC:
            begin
                res_full_reg     <= (op_reg == OP_ARRIVE) && !free_found;
                res_done_reg     <= done_now;
                res_done_job_reg <= done_now ? job_reg[run_slot_reg] : '0;
                res_fin_reg      <= done_now ? (now_reg + TIME_W'(1)) : '0;
                if (op_reg == OP_ARRIVE)
                begin
                    if (free_found)
                    begin
                        job_reg[free_idx]      <= id_reg;
                        need_arr_reg[free_idx] <= (need_reg == '0) ? NEED_W'(1) : need_reg;
                        waited_reg[free_idx]   <= '0;
                        seq_reg[free_idx]      <= next_seq_reg;
                    end
                end
                else if (run_active_reg)
                begin
                    for (int i = 0; i < MAX_JOBS; i++)
                    begin
                        if (valid_reg[i] && (IDX_W'(i) != run_slot_reg) &&
                            (waited_reg[i] != WAIT_MAX))
                        begin
                            waited_reg[i] <= waited_reg[i] + WAIT_W'(1);
                        end
                    end
                end
            end
            CMD_TAKE:
            begin
                best_sum_reg  <= cur_sum;
                best_need_reg <= cur_need;
                best_age_reg  <= cur_age;
            end
            CMD_MUL1:
            begin
                prod_a_reg <= prod;
            end
            CMD_MUL2:
            begin
                prod_b_reg <= prod;
            end
            CMD_CMP:
            begin
                if (beat)
                begin
                    best_sum_reg  <= cur_sum;
                    best_need_reg <= cur_need;
                    best_age_reg  <= cur_age;
                end
            end
            CMD_EMIT:
            begin
                out_data_reg <= OUT_TDATA_W'({res_full_reg, res_fin_reg, res_done_job_reg,
                                              res_done_reg, run_job, run_active_reg});
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/hjs_checker.sv -----
// Port-level checks of the HRRN job scheduler and their binding to the top level.
`timescale 1ns / 1ps

module hjs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hjs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import hjs_pkg::*;

    // A result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    // Without a completion the completion fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |->
            (m_axis_tdata[17:10] == '0) && (m_axis_tdata[49:18] == '0))
        else $error("completion fields set without a completion");

    // A dropped arrival cannot also complete a job, and an idle processor names no job.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            !(m_axis_tdata[50] && m_axis_tdata[9]) &&
            (m_axis_tdata[0] || (m_axis_tdata[8:1] == '0)))
        else $error("inconsistent result fields");

endmodule

bind hrrn_job_scheduler_unit hjs_checker u_hjs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
